@@ hw/rtl/tbsc_pkg.sv @@
package tbsc_pkg;

  localparam int StateBits = 288;
  localparam int KeyBits   = 80;
  localparam int IvBase    = 93;
  localparam int RegBBase  = 177;
  localparam int ByteBits  = 8;

  // register indexes on the configuration port
  localparam logic [1:0] RegKeyLow  = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegIvLow   = 2'd2;
  localparam logic [1:0] RegIvHigh  = 2'd3;

  typedef logic [StateBits-1:0] state_t;

  typedef struct packed {
    logic load;       // latch byte, reload state from key and IV
    logic step8;      // eight warm-up rounds
    logic step1;      // one warm-up round
    logic emit_new;   // eight rounds, output from the incoming byte
    logic emit_held;  // eight rounds, output from the held byte
  } cmd_t;

  function automatic logic round_z(input state_t s);
    round_z = s[65] ^ s[92] ^ s[161] ^ s[176] ^ s[242] ^ s[287];
  endfunction

  function automatic state_t round_next(input state_t s);
    logic   a;
    logic   b;
    logic   c;
    state_t n;
    a = s[65] ^ s[92] ^ (s[90] & s[91]) ^ s[170];
    b = s[161] ^ s[176] ^ (s[174] & s[175]) ^ s[263];
    c = s[242] ^ s[287] ^ (s[285] & s[286]) ^ s[68];
    n = {s[StateBits-2:0], 1'b0};
    n[0]        = c;
    n[IvBase]   = a;
    n[RegBBase] = b;
    round_next = n;
  endfunction

endpackage

@@ hw/rtl/trivium_byte_stream_cipher.sv @@
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] data_byte, tuser[0] new_message
// m_axis    out        tdata[7:0] cipher_byte
// apb       in/out     registers key_low, iv_low (64-bit), key_high, iv_high (16-bit) at 8*i
//
// A byte without new_message needs no warm-up: its eight rounds run in a single cycle.
// A byte with new_message runs through reload, warm-up at eight rounds a cycle,
// leftover rounds one a cycle, then output.
// Reset clears the cipher state and the registers; no clearing pass.
// A stalled output holds in its register and blocks the next byte until taken.
module trivium_byte_stream_cipher #(
  parameter int WARMUP_ROUNDS = 1152
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] new_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [63:0]    key_low_q;
  logic [15:0]    key_high_q;
  logic [63:0]    iv_low_q;
  logic [15:0]    iv_high_q;
  logic [1:0]     reg_idx;
  logic           wr_en;
  tbsc_pkg::cmd_t cmd;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_low_q   <= '0;
      iv_high_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        tbsc_pkg::RegKeyLow:  key_low_q  <= pwdata;
        tbsc_pkg::RegKeyHigh: key_high_q <= pwdata[15:0];
        tbsc_pkg::RegIvLow:   iv_low_q   <= pwdata;
        tbsc_pkg::RegIvHigh:  iv_high_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbsc_pkg::RegKeyLow:  prdata = key_low_q;
      tbsc_pkg::RegKeyHigh: prdata = {48'd0, key_high_q};
      tbsc_pkg::RegIvLow:   prdata = iv_low_q;
      tbsc_pkg::RegIvHigh:  prdata = {48'd0, iv_high_q};
      default:              prdata = '0;
    endcase
  end

  tbsc_ctrl #(
    .WARMUP_ROUNDS(WARMUP_ROUNDS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .new_message_i(s_axis_tuser[0]),
    .in_ready_o   (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cmd_o        (cmd)
  );

  tbsc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        ({key_high_q, key_low_q}),
    .iv_i         ({iv_high_q, iv_low_q}),
    .data_byte_i  (s_axis_tdata),
    .cipher_byte_o(m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // a message start blocks input for the warm-up
  a_warmup_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
    else $error("input taken during warm-up");

  // a plain byte yields its result on the next cycle
  a_plain_byte_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> m_axis_tvalid)
    else $error("plain byte produced no result");

  // no two datapath commands (load, warm-up steps, output) share a cycle
  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step8, cmd.step1, cmd.emit_new, cmd.emit_held}))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ hw/rtl/tbsc_ctrl.sv @@
module tbsc_ctrl #(
  parameter int WARMUP_ROUNDS = 1152
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          new_message_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tbsc_pkg::cmd_t cmd_o
);

  localparam int WarmOct = WARMUP_ROUNDS / 8;
  localparam int WarmRem = WARMUP_ROUNDS % 8;
  localparam int CntW    = $clog2(WARMUP_ROUNDS / 8 + 8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM8,
    ST_WARM1,
    ST_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && slot_free) begin
          if (new_message_i) begin
            cmd_o.load = 1'b1;
            if (WarmOct != 0) begin
              state_d = ST_WARM8;
              cnt_d   = CntW'(WarmOct - 1);
            end else begin
              state_d = ST_WARM1;
              cnt_d   = CntW'(WarmRem - 1);
            end
          end else begin
            cmd_o.emit_new = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      ST_WARM8: begin
        cmd_o.step8 = 1'b1;
        if (cnt_q == '0) begin
          if (WarmRem != 0) begin
            state_d = ST_WARM1;
            cnt_d   = CntW'(WarmRem - 1);
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_WARM1: begin
        cmd_o.step1 = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.emit_held = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/tbsc_dp.sv @@
module tbsc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tbsc_pkg::cmd_t                    cmd_i,
  input  logic [tbsc_pkg::KeyBits-1:0]      key_i,
  input  logic [tbsc_pkg::KeyBits-1:0]      iv_i,
  input  logic [tbsc_pkg::ByteBits-1:0]     data_byte_i,
  output logic [tbsc_pkg::ByteBits-1:0]     cipher_byte_o
);

  tbsc_pkg::state_t                  state_q, state_d;
  tbsc_pkg::state_t                  load_val;
  tbsc_pkg::state_t                  one_round;
  tbsc_pkg::state_t                  chain [tbsc_pkg::ByteBits+1];
  logic [tbsc_pkg::ByteBits-1:0]     ks;
  logic [tbsc_pkg::ByteBits-1:0]     byte_q;
  logic [tbsc_pkg::ByteBits-1:0]     out_q;
  logic                              adv8;

  assign adv8 = cmd_i.step8 || cmd_i.emit_new || cmd_i.emit_held;

  always_comb begin
    load_val = '0;
    load_val[tbsc_pkg::KeyBits-1:0] = key_i;
    load_val[tbsc_pkg::IvBase +: tbsc_pkg::KeyBits] = iv_i;
    load_val[tbsc_pkg::StateBits-1 -: 3] = 3'b111;
  end

  // eight rounds back to back, keystream bit k lands in bit k
  always_comb begin
    chain[0] = state_q;
    for (int k = 0; k < tbsc_pkg::ByteBits; k++) begin
      ks[k]      = tbsc_pkg::round_z(chain[k]);
      chain[k+1] = tbsc_pkg::round_next(chain[k]);
    end
  end

  assign one_round = tbsc_pkg::round_next(state_q);

  always_comb begin
    state_d = state_q;
    if (cmd_i.load) begin
      state_d = load_val;
    end else if (adv8) begin
      state_d = chain[tbsc_pkg::ByteBits];
    end else if (cmd_i.step1) begin
      state_d = one_round;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= data_byte_i;
    end
    if (cmd_i.emit_new) begin
      out_q <= data_byte_i ^ ks;
    end else if (cmd_i.emit_held) begin
      out_q <= byte_q ^ ks;
    end
  end

  assign cipher_byte_o = out_q;

endmodule

@@ tb/trivium_byte_stream_cipher_tb.sv @@
`timescale 1ns / 100ps

module trivium_byte_stream_cipher_tb;

  localparam int WarmupRounds = 1152;
  localparam int QuietLimit   = 4000;
  localparam int TailCycles   = 200;
  localparam int NumPhases    = 12;
  localparam int PhaseItems   = 105;

  typedef struct {
    int         setting;  // -1: keep the current key and IV
    logic [7:0] data;
    logic       new_msg;
    logic       typed;
    logic [7:0] want;
  } dir_row_t;

  typedef struct {
    logic [63:0] val [4];
  } key_setting_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser;   // [0] new_message
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] cipher_byte
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  logic [1:0]  reg_ids [4] = '{tbsc_pkg::RegKeyLow, tbsc_pkg::RegKeyHigh,
                               tbsc_pkg::RegIvLow, tbsc_pkg::RegIvHigh};
  logic [63:0] key_iv_regs [4];
  tbsc_pkg::state_t ks_state;
  logic [7:0]  cipher_exp_q [$];
  bit          calm;
  int          mismatches;
  int          bytes_sent;
  int          msg_starts;
  int          key_settings;
  int          results_checked;
  int          quiet_cycles;
  int          sink_left;

  key_setting_t key_table [3] = '{
    '{val: '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}},
    '{val: '{64'h5555_5555_5555_5555, 64'hDEAD_BEEF_0000_AAAA,
             64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_5555}},
    '{val: '{64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF}}
  };

  dir_row_t dir_rows [21] = '{
    // before any message start the zero state passes bytes through
    '{-1, 8'h00, 1'b0, 1'b1, 8'h00},
    '{-1, 8'hFF, 1'b0, 1'b1, 8'hFF},
    '{-1, 8'h01, 1'b0, 1'b1, 8'h01},
    '{-1, 8'h80, 1'b0, 1'b1, 8'h80},
    '{-1, 8'hA5, 1'b0, 1'b1, 8'hA5},
    '{-1, 8'h00, 1'b1, 1'b0, 8'h00},
    '{-1, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{-1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{-1, 8'h3C, 1'b1, 1'b0, 8'h00},
    '{-1, 8'hC3, 1'b0, 1'b0, 8'h00},
    '{0,  8'hFF, 1'b1, 1'b0, 8'h00},
    '{-1, 8'h00, 1'b0, 1'b0, 8'h00},
    '{-1, 8'h55, 1'b0, 1'b0, 8'h00},
    // new registers must not disturb the running message
    '{1,  8'h12, 1'b0, 1'b0, 8'h00},
    '{-1, 8'h00, 1'b1, 1'b0, 8'h00},
    '{-1, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{-1, 8'h7E, 1'b0, 1'b0, 8'h00},
    '{2,  8'h00, 1'b1, 1'b0, 8'h00},
    '{-1, 8'h81, 1'b0, 1'b0, 8'h00},
    '{-1, 8'hFF, 1'b1, 1'b0, 8'h00},
    '{-1, 8'h00, 1'b0, 1'b0, 8'h00}
  };

  trivium_byte_stream_cipher #(
    .WARMUP_ROUNDS(WarmupRounds)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic keystream_bit(inout tbsc_pkg::state_t s);
    logic ta;
    logic tb;
    logic tc;
    logic z;
    ta = s[65] ^ s[92];
    tb = s[161] ^ s[176];
    tc = s[242] ^ s[287];
    z  = ta ^ tb ^ tc;
    ta = ta ^ (s[90] & s[91]) ^ s[170];
    tb = tb ^ (s[174] & s[175]) ^ s[263];
    tc = tc ^ (s[285] & s[286]) ^ s[68];
    s = s << 1;
    s[0]                  = tc;
    s[tbsc_pkg::IvBase]   = ta;
    s[tbsc_pkg::RegBBase] = tb;
    return z;
  endfunction

  function automatic logic [7:0] predict_cipher_byte(logic [7:0] data, logic new_msg);
    logic [7:0] ks;
    if (new_msg) begin
      ks_state = '0;
      ks_state[tbsc_pkg::KeyBits-1:0] =
          {key_iv_regs[tbsc_pkg::RegKeyHigh][15:0], key_iv_regs[tbsc_pkg::RegKeyLow]};
      ks_state[tbsc_pkg::IvBase +: tbsc_pkg::KeyBits] =
          {key_iv_regs[tbsc_pkg::RegIvHigh][15:0], key_iv_regs[tbsc_pkg::RegIvLow]};
      ks_state[tbsc_pkg::StateBits-1 -: 3] = 3'b111;
      for (int n = 0; n < WarmupRounds; n++) begin
        void'(keystream_bit(ks_state));
      end
    end
    for (int k = 0; k < tbsc_pkg::ByteBits; k++) begin
      ks[k] = keystream_bit(ks_state);
    end
    return data ^ ks;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(logic [7:0] data, logic new_msg, logic typed, logic [7:0] want);
    logic [7:0] pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= new_msg;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_cipher_byte(data, new_msg);
    cipher_exp_q.push_back(typed ? want : pred);
    bytes_sent++;
    if (new_msg) msg_starts++;
    @(negedge clk_i);
  endtask

  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (cipher_exp_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // only the low 16 bits of the high halves exist
    if (idx == tbsc_pkg::RegKeyHigh || idx == tbsc_pkg::RegIvHigh) begin
      key_iv_regs[idx] = {48'h0, val[15:0]};
    end else begin
      key_iv_regs[idx] = val;
    end
    @(negedge clk_i);
  endtask

  task automatic apb_read_check(logic [1:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== key_iv_regs[idx]) begin
      $error("prdata of register %0d: expected %h, got %h", idx, key_iv_regs[idx], prdata);
      mismatches++;
    end
    @(negedge clk_i);
  endtask

  task automatic program_keys(logic [63:0] vals [4]);
    for (int i = 0; i < 4; i++) apb_write(reg_ids[i], vals[i]);
    for (int i = 0; i < 4; i++) apb_read_check(reg_ids[i]);
    psel    <= 1'b0;
    penable <= 1'b0;
    key_settings++;
    @(negedge clk_i);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    sink_left     = 0;
    forever begin
      @(negedge clk_i);
      if (sink_left == 0) begin
        if (calm) begin
          m_axis_tready <= 1'b1;
          sink_left = 1;
        end else begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
          sink_left = $urandom_range(1, 17);
        end
      end
      sink_left--;
    end
  end

  always @(posedge clk_i) begin
    logic [7:0] exp_byte;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_exp_q.size() == 0) begin
        $error("cipher_byte: expected none, got %02h", m_axis_tdata);
        mismatches++;
      end else begin
        exp_byte = cipher_exp_q.pop_front();
        results_checked++;
        if (m_axis_tdata !== exp_byte) begin
          $error("cipher_byte: expected %02h, got %02h", exp_byte, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("trivium_byte_stream_cipher_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [63:0] vals [4];
    int          n;
    int          len;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    calm            = 1'b0;
    mismatches      = 0;
    bytes_sent      = 0;
    msg_starts      = 0;
    key_settings    = 0;
    results_checked = 0;
    quiet_cycles    = 0;
    ks_state        = '0;
    for (int i = 0; i < 4; i++) key_iv_regs[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].setting >= 0) begin
        drain_stream();
        program_keys(key_table[dir_rows[r].setting].val);
      end
      send_byte(dir_rows[r].data, dir_rows[r].new_msg, dir_rows[r].typed, dir_rows[r].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_stream();
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 4))
          0:       vals[i] = '0;
          1:       vals[i] = '1;
          default: vals[i] = {$urandom, $urandom};
        endcase
      end
      program_keys(vals);
      calm = (ph == NumPhases - 1);
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(0, 9) != 0) begin
          // well-formed message: start byte, then a run of plain bytes
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(0, 24);
          send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 8'h00);
          for (int j = 0; j < len; j++) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, 8'h00);
          n += len + 1;
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, 8'h00);
          n++;
        end
      end
    end

    drain_stream();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d bytes with %0d message starts under %0d key/IV settings;",
             bytes_sent, msg_starts, key_settings);
    $display("checked %0d cipher bytes with random stalls on both streams.", results_checked);
    if (mismatches == 0) begin
      $display("trivium_byte_stream_cipher_tb OK");
    end else begin
      $display("trivium_byte_stream_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ trivium_byte_stream_cipher.f @@
hw/rtl/tbsc_pkg.sv
hw/rtl/tbsc_ctrl.sv
hw/rtl/tbsc_dp.sv
hw/rtl/trivium_byte_stream_cipher.sv
tb/trivium_byte_stream_cipher_tb.sv
